// ----- sv/psfp_pkg.sv -----
package psfp_pkg;

    // Frame layout, by byte position within the 32-byte frame
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_PREAMBLE_END = 5'd4;
    localparam logic [POS_W-1:0] POS_FIRST_WORD   = 5'd5;
    localparam logic [POS_W-1:0] POS_VERSION      = 5'd28;
    localparam logic [POS_W-1:0] POS_CSUM_HIGH    = 5'd30;
    localparam logic [POS_W-1:0] POS_FRAME_LAST   = 5'd31;

    localparam logic [3:0] IDX_CHECKSUM = 4'd14;

    // Preamble bytes in arrival order
    localparam logic [7:0] PREAMBLE [4] = '{8'h42, 8'h4D, 8'h00, 8'h1C};

    typedef enum logic [1:0] {
        ST_FIELD    = 2'd0,
        ST_SUM_GOOD = 2'd1,
        ST_SUM_BAD  = 2'd2,
        ST_REJECT   = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  field_index;
        logic [15:0] value;
        logic        last;
    } result_t;

endpackage

// ----- sv/psfp_parse.sv -----
module psfp_parse
    import psfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       res_free,
    output logic       res_load,
    output result_t    res
);

    logic             a_valid_reg;
    logic             a_valid_next;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [7:0]       held_reg;
    logic [7:0]       held_next;
    logic             has_res;
    logic             a_fire;
    logic             in_xfer;
    logic [POS_W-1:0] word_off;
    logic [15:0]      received;
    logic [15:0]      sum_add;

    // An item without a result never waits on the result register
    assign a_fire   = a_valid_reg && (res_free || !has_res);
    assign in_stall = a_valid_reg && !a_fire;
    assign in_xfer  = in_valid && !in_stall;
    assign res_load = a_fire && has_res;

    assign word_off = pos_reg - POS_FIRST_WORD;
    assign received = {held_reg, byte_reg};
    assign sum_add  = sum_reg + {8'd0, byte_reg};

    // Decode the held byte against the frame position
    always_comb
    begin
        pos_next  = pos_reg + 5'd1;
        sum_next  = sum_add;
        held_next = held_reg;
        has_res   = 1'b0;
        res       = '{status: ST_FIELD, field_index: 4'd0, value: 16'd0, last: 1'b0};
        if (pos_reg < POS_PREAMBLE_END)
        begin
            if (byte_reg != PREAMBLE[pos_reg[1:0]])
            begin
                has_res   = 1'b1;
                res       = '{status: ST_REJECT, field_index: {2'd0, pos_reg[1:0]},
                              value: {8'd0, byte_reg}, last: 1'b1};
                pos_next  = '0;
                sum_next  = '0;
            end
        end
        else if (pos_reg < POS_CSUM_HIGH)
        begin
            if (pos_reg >= POS_VERSION)
            begin
                has_res = 1'b1;
                res     = '{status: ST_FIELD, field_index: pos_reg[3:0],
                            value: {8'd0, byte_reg}, last: 1'b0};
            end
            else if (!pos_reg[0])
            begin
                held_next = byte_reg;
            end
            else
            begin
                has_res = 1'b1;
                res     = '{status: ST_FIELD, field_index: word_off[4:1],
                            value: received, last: 1'b0};
            end
        end
        else if (pos_reg == POS_CSUM_HIGH)
        begin
            held_next = byte_reg;
            sum_next  = sum_reg;
        end
        else
        begin
            has_res  = 1'b1;
            res      = '{status: (received == sum_reg) ? ST_SUM_GOOD : ST_SUM_BAD,
                         field_index: IDX_CHECKSUM, value: received, last: 1'b1};
            pos_next = '0;
            sum_next = '0;
        end
    end

    // Hold the input byte until it is decoded
    always_comb
    begin
        if (in_xfer)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    // Advance frame state on each decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            held_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (a_fire)
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                held_reg <= held_next;
            end
        end
    end

    // Capture the incoming byte
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

// ----- sv/psfp_out_reg.sv -----
module psfp_out_reg
    import psfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_load,
    input  result_t res,
    output logic    res_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    r_valid_reg;
    logic    r_valid_next;
    result_t r_data_reg;

    assign res_free  = !r_valid_reg || !out_stall;
    assign out_valid = r_valid_reg;
    assign out_res   = r_data_reg;

    // Drop the result once transferred, unless a new one replaces it
    always_comb
    begin
        if (res_load)
        begin
            r_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            r_valid_next = 1'b0;
        end
        else
        begin
            r_valid_next = r_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= r_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            r_data_reg <= res;
        end
    end

endmodule

// ----- sv/particle_sensor_frame_parser_top.sv -----
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// input   | in_valid / in_stall  | byte_in[7:0]
// output  | out_valid / out_stall| status[1:0] field_index[3:0] value[15:0] last
//
// One byte per cycle is sustained while the output does not back up into in_stall;
// a result is decoded from the input register and then loaded into the result register.
// Bytes that complete no field pass through without using the result register.
// Reset returns the parser to the preamble hunt with a cleared checksum sum.
// A stall on the output backs up into in_stall only when the result register is
// full and the held byte yields a result.
module particle_sensor_frame_parser_top
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  field_index,
    output logic [15:0] value,
    output logic        last
);

    logic    res_free;
    logic    res_load;
    result_t res;
    result_t out_res;

    psfp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .byte_in  (byte_in),
        .res_free (res_free),
        .res_load (res_load),
        .res      (res)
    );

    psfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .res_free  (res_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status      = out_res.status;
    assign field_index = out_res.field_index;
    assign value       = out_res.value;
    assign last        = out_res.last;

    // An empty result register never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // Field values never close a frame; frame ends and rejections always do
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != ST_FIELD)))
        else $error("last flag disagrees with status");

    // Rejections name a preamble position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_REJECT) |-> (field_index < 4'd4))
        else $error("rejection index outside preamble");

    // Frame end always carries the checksum index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_SUM_GOOD || status == ST_SUM_BAD))
            |-> (field_index == IDX_CHECKSUM))
        else $error("frame end without checksum index");

endmodule

// ----- tb/sv/psfp_frame_check.sv -----
`timescale 1ns / 1ps

// Watches both channels of the frame parser, predicts each result from the
// bytes that go in, and compares every result that comes out.
module psfp_frame_check
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [3:0]  field_index,
    input  logic [15:0] value,
    input  logic        last,
    output int          mismatches,
    output int          awaited,
    output int          good_frames,
    output int          bad_frames,
    output int          rejections,
    output int          field_values
);

    // Predicted parser state
    logic [4:0]  frame_pos;
    logic [15:0] byte_sum;
    logic [7:0]  high_byte;

    // Results still owed by the block, oldest first
    result_t decoded_fields [$];

    // Advance the predicted parser by one byte and queue any result it owes
    task automatic parse_byte(input logic [7:0] b);
        result_t     r;
        logic [4:0]  pos;
        logic [15:0] received;
        pos = frame_pos;
        r.status      = ST_FIELD;
        r.field_index = 4'd0;
        r.value       = 16'd0;
        r.last        = 1'b0;
        if (pos < POS_PREAMBLE_END)
        begin
            if (b != PREAMBLE[pos[1:0]])
            begin
                // broken preamble: reject, drop the byte and restart the hunt
                r.status      = ST_REJECT;
                r.field_index = {2'b00, pos[1:0]};
                r.value       = {8'h00, b};
                r.last        = 1'b1;
                decoded_fields.push_back(r);
                frame_pos = 5'd0;
                byte_sum  = 16'd0;
            end
            else
            begin
                byte_sum  = byte_sum + {8'h00, b};
                frame_pos = pos + 5'd1;
            end
        end
        else if (pos < POS_CSUM_HIGH)
        begin
            byte_sum  = byte_sum + {8'h00, b};
            frame_pos = pos + 5'd1;
            if (pos >= POS_VERSION)
            begin
                // version and error code are single bytes
                r.field_index = 4'(pos - 5'd16);
                r.value       = {8'h00, b};
                decoded_fields.push_back(r);
            end
            else if (pos[0] == 1'b0)
            begin
                high_byte = b;
            end
            else
            begin
                r.field_index = 4'((pos - POS_FIRST_WORD) >> 1);
                r.value       = {high_byte, b};
                decoded_fields.push_back(r);
            end
        end
        else if (pos == POS_CSUM_HIGH)
        begin
            high_byte = b;
            frame_pos = pos + 5'd1;
        end
        else
        begin
            // frame end: judge the received checksum against the sum
            received      = {high_byte, b};
            r.status      = (received == byte_sum) ? ST_SUM_GOOD : ST_SUM_BAD;
            r.field_index = IDX_CHECKSUM;
            r.value       = received;
            r.last        = 1'b1;
            decoded_fields.push_back(r);
            frame_pos = 5'd0;
            byte_sum  = 16'd0;
        end
    endtask

    task automatic report(input string name, input logic [15:0] want, input logic [15:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
    endtask

    // Compare output transfers first, then predict from the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            frame_pos = 5'd0;
            byte_sum  = 16'd0;
            high_byte = 8'd0;
            decoded_fields.delete();
            mismatches   = 0;
            good_frames  = 0;
            bad_frames   = 0;
            rejections   = 0;
            field_values = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_fields.size() == 0)
                begin
                    $display("%0t: expected no result, got status %0d index %0d value %0h last %0b",
                             $time, status, field_index, value, last);
                    mismatches++;
                end
                else
                begin
                    want = decoded_fields.pop_front();
                    if (status !== want.status)
                        report("status", 16'(want.status), 16'(status));
                    if (field_index !== want.field_index)
                        report("field_index", 16'(want.field_index), 16'(field_index));
                    if (value !== want.value)
                        report("value", want.value, value);
                    if (last !== want.last)
                        report("last", 16'(want.last), 16'(last));
                    case (want.status)
                        ST_FIELD:    field_values++;
                        ST_SUM_GOOD: good_frames++;
                        ST_SUM_BAD:  bad_frames++;
                        default:     rejections++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
                parse_byte(byte_in);
        end
        awaited = decoded_fields.size();
    end

endmodule

// ----- tb/sv/particle_sensor_frame_parser_top_test.sv -----
`timescale 1ns / 1ps

module particle_sensor_frame_parser_top_test;
    import psfp_pkg::*;

    localparam int RANDOM_BYTES   = 1200;
    localparam int PHASE_BYTES    = 160;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int BODY_BYTES     = 26;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [3:0]  field_index;
    logic [15:0] value;
    logic        last;

    int mismatches;
    int awaited;
    int good_frames;
    int bad_frames;
    int rejections;
    int field_values;

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    bit long_hold_req;

    particle_sensor_frame_parser_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .field_index (field_index),
        .value       (value),
        .last        (last)
    );

    psfp_frame_check frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .field_index  (field_index),
        .value        (value),
        .last         (last),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .good_frames  (good_frames),
        .bad_frames   (bad_frames),
        .rejections   (rejections),
        .field_values (field_values)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when asked for
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run once nothing has transferred for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, awaited);
        $display("particle_sensor_frame_parser_top: mismatch");
        $finish;
    end

    // Offer one byte, with random idle cycles first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Lower valid and wait until every owed result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited != 0);
    endtask

    // Send a whole frame; extremes alternate all-ones and all-zero words
    task automatic send_frame(input bit sum_ok, input bit extremes);
        logic [7:0]  b;
        logic [15:0] csum;
        csum = 16'd0;
        for (int i = 0; i < 4; i++)
        begin
            csum = csum + {8'h00, PREAMBLE[i]};
            send_byte(PREAMBLE[i]);
        end
        for (int i = 0; i < BODY_BYTES; i++)
        begin
            if (extremes)
                b = ((i % 4) < 2) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom);
            csum = csum + {8'h00, b};
            send_byte(b);
        end
        if (!sum_ok)
            csum = csum ^ 16'($urandom_range(65535, 1));
        send_byte(csum[15:8]);
        send_byte(csum[7:0]);
    endtask

    // Send a frame cut short after the preamble; the parser loses alignment
    task automatic send_cut_frame();
        int body_len;
        body_len = $urandom_range(BODY_BYTES - 1, 1);
        for (int i = 0; i < 4; i++)
            send_byte(PREAMBLE[i]);
        for (int i = 0; i < body_len; i++)
            send_byte(8'($urandom));
    endtask

    // Stimulus
    initial
    begin : stimulus
        int pick;
        int phase;
        int part_len;
        bit held;
        bit paused;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_in        = 8'h00;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        long_hold_req  = 1'b0;
        held           = 1'b0;
        paused         = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Preamble broken at each position, including a repeated first byte
        send_byte(8'h00);
        send_byte(8'h42);
        send_byte(8'hFF);
        send_byte(8'h42);
        send_byte(8'h42);
        send_byte(8'h42);
        send_byte(8'h4D);
        send_byte(8'h1C);
        send_byte(8'h42);
        send_byte(8'h4D);
        send_byte(8'h00);
        send_byte(8'h00);
        // Full frame with extreme words and a good checksum
        send_frame(1'b1, 1'b1);
        drain_results();

        // Random frames, cut frames, partial preambles and noise
        while (bytes_sent < RANDOM_BYTES)
        begin
            phase = (bytes_sent / PHASE_BYTES) % 4;
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            if (!held && bytes_sent >= 400)
            begin
                // hold the receiver off so the block backs up into in_stall
                held = 1'b1;
                send_idle_pct  = 0;
                long_hold_req  = 1'b1;
            end
            if (!paused && bytes_sent >= 800)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(99);
            if (pick < 72)
                send_frame($urandom_range(99) < 80, 1'b0);
            else if (pick < 80)
                send_cut_frame();
            else if (pick < 90)
            begin
                part_len = $urandom_range(3, 1);
                for (int i = 0; i < part_len; i++)
                    send_byte(PREAMBLE[i]);
                send_byte(8'($urandom));
            end
            else
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end

        // Let every owed result out, then allow for stray ones
        recv_stall_pct = 0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d bytes over four idle/stall mixes with one long hold-off.",
                 bytes_sent);
        $display("Checked %0d good frames, %0d bad frames, %0d rejections, %0d fields.",
                 good_frames, bad_frames, rejections, field_values);
        if (mismatches == 0 && awaited == 0)
            $display("particle_sensor_frame_parser_top: match");
        else
            $display("particle_sensor_frame_parser_top: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/psfp_pkg.sv
sv/psfp_parse.sv
sv/psfp_out_reg.sv
sv/particle_sensor_frame_parser_top.sv
tb/sv/psfp_frame_check.sv
tb/sv/particle_sensor_frame_parser_top_test.sv
